@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/puf_pkg.sv @@
// shared types and constants of the packed field unpacker
// no dependencies; used by every module of the block
package puf_pkg;

    localparam int ACC_BITS       = 40;
    localparam int BYTE_BITS      = 8;
    localparam int FB_BITS        = 6;
    localparam int VCOUNT_BITS    = 24;
    localparam int VALUE_BITS     = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int RUN_MAX        = 8;
    localparam int RUN_CNT_BITS   = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = 2;

    localparam logic [FB_BITS-1:0]    FIELD_BITS_RESET = 6'd16;
    localparam logic [VALUE_BITS-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_BITS-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FIELD_BITS  = 3'd0,
        CFG_VALUE_COUNT = 3'd1,
        CFG_MIN_VALUE   = 3'd2,
        CFG_MAX_VALUE   = 3'd3,
        CFG_STEP_SCALE  = 3'd4,
        CFG_MIN_ONLY    = 3'd5
    } cfg_index_t;

    // per-code flags passed from front to back
    typedef struct packed {
        logic sub_sel;      // scale down from max_value
        logic run_end;      // last code of this byte
        logic message_end;  // value_count-th code
    } puf_tag_t;

    // arithmetic operands for the back end
    typedef struct packed {
        logic [VALUE_BITS-1:0] min_value;
        logic [VALUE_BITS-1:0] max_value;
        logic [VALUE_BITS-1:0] step_scale;
    } puf_arith_cfg_t;

endpackage

@@ hdl/puf_front.sv @@
// front end: takes bytes, holds the bit accumulator, cuts codes and classifies them
// depends on puf_pkg; feeds puf_queue
module puf_front #(
    parameter int MAX_CODE_BITS = 32,
    parameter int COUNT_BITS    = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [puf_pkg::BYTE_BITS-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic [puf_pkg::FB_BITS-1:0]         field_bits,
    input  logic [puf_pkg::VCOUNT_BITS-1:0]     value_count,
    input  logic                                min_only_mode,
    output logic                                q_push,
    output logic [MAX_CODE_BITS-1:0]            q_k,
    output puf_pkg::puf_tag_t                   q_tag,
    input  logic                                q_full
);
    import puf_pkg::*;

    localparam logic [FB_BITS-1:0] MAX_FB = FB_BITS'(MAX_CODE_BITS);

    logic [ACC_BITS-1:0]      acc_reg, acc_next;
    logic [FB_BITS-1:0]       held_reg, held_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [RUN_CNT_BITS-1:0]  nres_reg, nres_next;
    logic                     busy_reg, busy_next;

    logic [FB_BITS-1:0]       fb;
    logic [MAX_CODE_BITS-1:0] ones;
    logic [MAX_CODE_BITS-1:0] half_mask;
    logic [COUNT_BITS-1:0]    vc;
    logic [FB_BITS-1:0]       held_sub;
    logic [ACC_BITS-1:0]      shifted;
    logic [MAX_CODE_BITS-1:0] code;
    logic [COUNT_BITS-1:0]    count_inc;
    logic                     can_emit, emit, last, msg_end, upper, sub_sel, step_done;

    // effective width, code masks and message length
    always_comb begin
        if (field_bits == '0) begin
            fb = FB_BITS'(1);
        end else if (field_bits > MAX_FB) begin
            fb = MAX_FB;
        end else begin
            fb = field_bits;
        end
    end
    assign ones      = {MAX_CODE_BITS{1'b1}} >> (MAX_FB - fb);
    assign half_mask = ones ^ (ones >> 1);
    assign vc        = COUNT_BITS'(value_count);

    // next code out of the accumulator
    assign held_sub  = held_reg - fb;
    assign shifted   = acc_reg >> held_sub;
    assign code      = shifted[MAX_CODE_BITS-1:0] & ones;
    assign upper     = |(code & half_mask);
    assign sub_sel   = upper && !min_only_mode;
    assign count_inc = count_reg + COUNT_BITS'(1);
    assign msg_end   = (count_inc == vc);
    assign last      = (nres_reg == RUN_CNT_BITS'(RUN_MAX - 1)) || (held_sub < fb) || msg_end;

    assign can_emit  = busy_reg && (held_reg >= fb) && (count_reg < vc);
    assign emit      = can_emit && !q_full;
    assign step_done = busy_reg && (!can_emit || (emit && last));
    assign s_tready  = !busy_reg || step_done;

    assign q_push = emit;
    assign q_k    = sub_sel ? (ones ^ code) : code;
    assign q_tag  = '{sub_sel: sub_sel, run_end: last, message_end: msg_end};

    // finish the current byte, then take a new one on top of what is left
    always_comb begin
        acc_next   = acc_reg;
        held_next  = held_reg;
        count_next = count_reg;
        nres_next  = nres_reg;
        busy_next  = busy_reg;
        if (emit) begin
            held_next  = held_sub;
            count_next = count_inc;
            nres_next  = nres_reg + RUN_CNT_BITS'(1);
            if (msg_end) begin
                held_next = '0;
            end
        end
        if (step_done) begin
            busy_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            if (s_tuser) begin
                acc_next   = '0;
                held_next  = '0;
                count_next = '0;
            end
            // a complete message ignores further bytes
            if (count_next < vc) begin
                acc_next  = {acc_next[ACC_BITS-BYTE_BITS-1:0], s_tdata};
                held_next = held_next + FB_BITS'(BYTE_BITS);
                nres_next = '0;
                busy_next = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            count_reg <= '0;
            nres_reg  <= '0;
            busy_reg  <= 1'b0;
        end else begin
            held_reg  <= held_next;
            count_reg <= count_next;
            nres_reg  <= nres_next;
            busy_reg  <= busy_next;
        end
    end

    // accumulator bits are only read below the held count
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

endmodule

@@ hdl/puf_queue.sv @@
// short queue between the front and back ends
// depends on puf_pkg for its depth
module puf_queue #(
    parameter int DATA_W = 35
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);
    import puf_pkg::*;

    logic [DATA_W-1:0]    slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   fill_reg;

    assign full     = (fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (QPTR_BITS+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (QPTR_BITS+1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/puf_back.sv @@
// back end: split multiply, product clamp, clamped add or subtract, output register
// depends on puf_pkg; reads puf_queue
module puf_back #(
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  logic [MAX_CODE_BITS-1:0]            q_k,
    input  puf_pkg::puf_tag_t                   q_tag,
    output logic                                q_pop,
    input  puf_pkg::puf_arith_cfg_t             arith_cfg,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [puf_pkg::VALUE_BITS-1:0]      m_tdata,  // value
    output logic                                m_tlast,  // run_end
    output logic [1:0]                          m_tuser   // message_end, saturated
);
    import puf_pkg::*;

    localparam int LW = 32 + MAX_CODE_BITS;
    localparam int HW = 33 + MAX_CODE_BITS;
    localparam int PW = 65 + MAX_CODE_BITS;

    logic                  advance;
    logic                  v1_reg, v2_reg, m_tvalid_reg;
    logic [LW-1:0]         p_lo_reg;
    logic signed [HW-1:0]  p_hi_reg;
    puf_tag_t              tag1_reg, tag2_reg;
    logic [VALUE_BITS-1:0] prod_reg;
    logic                  psat_reg;
    logic [VALUE_BITS-1:0] m_tdata_reg;
    logic                  m_tlast_reg;
    logic [1:0]            m_tuser_reg;

    logic [PW-1:0]         prod;
    logic                  prod_fits;
    logic [VALUE_BITS-1:0] base, sum, value;
    logic                  ovf;

    // whole pipeline moves when the output register is free
    assign advance = !m_tvalid_reg || m_tready;
    assign q_pop   = advance && !q_empty;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg       <= !q_empty;
            v2_reg       <= v1_reg;
            m_tvalid_reg <= v2_reg;
        end
    end

    // stage 1: scale times code, as low and high 32-bit halves of the scale
    always_ff @(posedge aclk) begin
        if (advance) begin
            p_lo_reg <= LW'(arith_cfg.step_scale[31:0]) * LW'(q_k);
            p_hi_reg <= HW'($signed(arith_cfg.step_scale[63:32])) * HW'($signed({1'b0, q_k}));
            tag1_reg <= q_tag;
        end
    end

    // stage 2: join halves, clamp to 64 bits
    assign prod      = {p_hi_reg, 32'b0} + {33'b0, p_lo_reg};
    assign prod_fits = (&prod[PW-1:VALUE_BITS-1]) || !(|prod[PW-1:VALUE_BITS-1]);

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_fits ? prod[VALUE_BITS-1:0] : (prod[PW-1] ? NEG_LIMIT : POS_LIMIT);
            psat_reg <= !prod_fits;
            tag2_reg <= tag1_reg;
        end
    end

    // stage 3: offset from min or max, clamped
    assign base = tag2_reg.sub_sel ? arith_cfg.max_value : arith_cfg.min_value;
    assign sum  = tag2_reg.sub_sel ? (base - prod_reg) : (base + prod_reg);
    always_comb begin
        if (tag2_reg.sub_sel) begin
            ovf = (base[VALUE_BITS-1] != prod_reg[VALUE_BITS-1]) &&
                  (base[VALUE_BITS-1] != sum[VALUE_BITS-1]);
        end else begin
            ovf = (base[VALUE_BITS-1] == prod_reg[VALUE_BITS-1]) &&
                  (base[VALUE_BITS-1] != sum[VALUE_BITS-1]);
        end
    end
    assign value = ovf ? (base[VALUE_BITS-1] ? NEG_LIMIT : POS_LIMIT) : sum;

    // output register
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= value;
            m_tlast_reg <= tag2_reg.run_end;
            m_tuser_reg <= {psat_reg || ovf, tag2_reg.message_end};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ hdl/packed_field_unpacker.sv @@
// channel   dir  beat contents
// s_        in   tdata: in_byte; tuser: start_message
// m_        out  tdata: value; tlast: run_end; tuser: message_end, saturated
// cfg_      in   cfg_index: register index; cfg_data: register value
//
// while the queue has room, the front takes one byte a cycle if each byte yields
// at most one code; a byte with up to 8 codes holds the front, one code a cycle
// the back end adds three register stages after the 4-entry queue, one value a cycle
// output stalls fill the queue and then hold s_tready low; cfg_ready is always high
// synchronous active-low reset clears the bit count, code count and all valid bits
//
// top level of the packed field unpacker: configuration registers and the three parts
// depends on puf_pkg, puf_front, puf_queue, puf_back and assert_macros.svh
`include "assert_macros.svh"

module packed_field_unpacker #(
    parameter int MAX_CODE_BITS = 32,
    parameter int COUNT_BITS    = 24
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [puf_pkg::BYTE_BITS-1:0]            s_tdata,   // in_byte
    input  logic                                     s_tuser,   // start_message
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [puf_pkg::VALUE_BITS-1:0]           m_tdata,   // value
    output logic                                     m_tlast,   // run_end
    output logic [1:0]                               m_tuser,   // message_end, saturated
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [puf_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [puf_pkg::VALUE_BITS-1:0]           cfg_data
);
    import puf_pkg::*;

    localparam int QDATA_W = $bits(puf_tag_t) + MAX_CODE_BITS;

    logic [FB_BITS-1:0]     field_bits_reg;
    logic [VCOUNT_BITS-1:0] value_count_reg;
    logic [VALUE_BITS-1:0]  min_value_reg, max_value_reg, step_scale_reg;
    logic                   min_only_reg;

    logic                     q_push, q_full, q_pop, q_empty;
    logic [MAX_CODE_BITS-1:0] front_k;
    puf_tag_t                 front_tag;
    logic [QDATA_W-1:0]       q_out;
    puf_tag_t                 back_tag;
    logic [MAX_CODE_BITS-1:0] back_k;
    puf_arith_cfg_t           arith_cfg;
    logic                     start_empty_msg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_bits_reg  <= FIELD_BITS_RESET;
            value_count_reg <= '0;
            min_value_reg   <= '0;
            max_value_reg   <= '0;
            step_scale_reg  <= '0;
            min_only_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FIELD_BITS:  field_bits_reg  <= cfg_data[FB_BITS-1:0];
                CFG_VALUE_COUNT: value_count_reg <= cfg_data[VCOUNT_BITS-1:0];
                CFG_MIN_VALUE:   min_value_reg   <= cfg_data;
                CFG_MAX_VALUE:   max_value_reg   <= cfg_data;
                CFG_STEP_SCALE:  step_scale_reg  <= cfg_data;
                CFG_MIN_ONLY:    min_only_reg    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign arith_cfg = '{min_value: min_value_reg, max_value: max_value_reg,
                         step_scale: step_scale_reg};

    // front end
    puf_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .field_bits    (field_bits_reg),
        .value_count   (value_count_reg),
        .min_only_mode (min_only_reg),
        .q_push        (q_push),
        .q_k           (front_k),
        .q_tag         (front_tag),
        .q_full        (q_full)
    );

    // code queue
    puf_queue #(
        .DATA_W (QDATA_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({front_tag, front_k}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign back_tag = q_out[QDATA_W-1:MAX_CODE_BITS];
    assign back_k   = q_out[MAX_CODE_BITS-1:0];

    // back end
    puf_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_k       (back_k),
        .q_tag     (back_tag),
        .q_pop     (q_pop),
        .arith_cfg (arith_cfg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // start beat of a message with zero codes
    assign start_empty_msg = s_tvalid && s_tready && s_tuser && (value_count_reg == '0);

    // checks
    `ASSERT_IMPLY(a_push_has_room, aclk, aresetn, q_push, !q_full)
    `ASSERT_IMPLY(a_pop_has_entry, aclk, aresetn, q_pop, !q_empty)
    `ASSERT_IMPLY(a_stall_holds_queue, aclk, aresetn, m_tvalid && !m_tready, !q_pop)
    `ASSERT_NEXT(a_empty_message_quiet, aclk, aresetn, start_empty_msg, !q_push)

endmodule
